@@ sv/ptd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_pkg
// Types and widths shared by the point to triangle distance core.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int COORD_W  = 32;
  localparam int DEFAULT_COORD_WIDTH = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int BDIFF_W  = COORD_W + 3;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int BPROD_W  = 2 * BDIFF_W;
  localparam int BCROSS_W = BPROD_W + 1;
  localparam int RAD_W    = PROD_W;
  localparam int ROOT_W   = DIFF_W;
  localparam int TEST_W   = RAD_W + 2;
  localparam int DIST_W   = 31;
  localparam int GRAD_W   = 16;
  localparam int GFRAC    = 14;
  localparam int GQ_W     = GFRAC + 1;
  localparam int GNUM_W   = DIFF_W + GFRAC;
  localparam int GRAD_ONE = 1 << GFRAC;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic                      action;
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic signed [COORD_W-1:0] corner0_x;
    logic signed [COORD_W-1:0] corner0_y;
    logic signed [COORD_W-1:0] corner1_x;
    logic signed [COORD_W-1:0] corner1_y;
    logic signed [COORD_W-1:0] corner2_x;
    logic signed [COORD_W-1:0] corner2_y;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0]        distance;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic                     contained;
    logic                     degenerate;
  } out_t;

  typedef struct packed {
    logic action;
    logic degenerate;
    logic in0;
    logic in1;
    logic perp;
    logic gx_neg;
    logic gy_neg;
  } ctl_t;

  typedef struct packed {
    ctl_t              ctl;
    logic [RAD_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  num;
    logic [DIFF_W-1:0] gx_mag;
    logic [DIFF_W-1:0] gy_mag;
  } sq_t;

  typedef struct packed {
    ctl_t              ctl;
    logic              sat;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  drem;
    logic [DIST_W-1:0] dq;
    logic [GNUM_W-1:0] xrem;
    logic [GNUM_W-1:0] yrem;
    logic [GQ_W-1:0]   xq;
    logic [GQ_W-1:0]   yq;
  } dv_t;

endpackage
`default_nettype wire

@@ sv/point_triangle_external_distance_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// point_triangle_external_distance_core
// Pipelined 2D point to triangle distance and parallelogram containment.
// ----------------------------------------------------------------------------
// Accepts one query per cycle while the output is not stalled and returns
// results in order. Most of the depth is the 33-stage square root (one root
// bit per stage) followed by the 31-stage distance divider (one quotient bit
// per stage, the gradient dividers run alongside in its first 15 stages). The
// whole pipeline advances together: it holds while a result sits on the
// output without a transfer, and empty slots fill as soon as it moves.
module point_triangle_external_distance_core #(
  parameter int COORD_WIDTH = ptd_pkg::DEFAULT_COORD_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ptd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ptd_pkg::out_t out_data
);
  import ptd_pkg::*;

  localparam int CW = (COORD_WIDTH < COORD_W) ? COORD_WIDTH : COORD_W;

  function automatic logic signed [COORD_W-1:0] sext(input logic [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    for (int i = 0; i < COORD_W; i++) begin
      r[i] = (i < CW) ? v[i] : v[CW-1];
    end
    return r;
  endfunction

  function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] r;
    r = v[DIFF_W-1] ? $unsigned(-v) : $unsigned(v);
    return r;
  endfunction

  logic en;
  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  // stage 1: sign-extended coordinates
  logic                      v1, act1;
  logic signed [COORD_W-1:0] qx1, qy1;
  logic signed [COORD_W-1:0] px1 [3];
  logic signed [COORD_W-1:0] py1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      act1   <= in_data.action;
      qx1    <= sext(in_data.query_x);
      qy1    <= sext(in_data.query_y);
      px1[0] <= sext(in_data.corner0_x);
      py1[0] <= sext(in_data.corner0_y);
      px1[1] <= sext(in_data.corner1_x);
      py1[1] <= sext(in_data.corner1_y);
      px1[2] <= sext(in_data.corner2_x);
      py1[2] <= sext(in_data.corner2_y);
    end
  end

  // stage 2: edges and point offsets of both triangles
  logic signed [BDIFF_W-1:0] sbx [3];
  logic signed [BDIFF_W-1:0] sby [3];

  always_comb begin
    sbx[0] = BDIFF_W'(px1[2]);
    sby[0] = BDIFF_W'(py1[2]);
    sbx[1] = BDIFF_W'(px1[1]);
    sby[1] = BDIFF_W'(py1[1]);
    sbx[2] = BDIFF_W'(px1[1]) + BDIFF_W'(px1[2]) - BDIFF_W'(px1[0]);
    sby[2] = BDIFF_W'(py1[1]) + BDIFF_W'(py1[2]) - BDIFF_W'(py1[0]);
  end

  logic                      v2, act2, deg2;
  logic signed [DIFF_W-1:0]  eax2 [3];
  logic signed [DIFF_W-1:0]  eay2 [3];
  logic signed [DIFF_W-1:0]  wax2 [3];
  logic signed [DIFF_W-1:0]  way2 [3];
  logic signed [BDIFF_W-1:0] ebx2 [3];
  logic signed [BDIFF_W-1:0] eby2 [3];
  logic signed [BDIFF_W-1:0] wbx2 [3];
  logic signed [BDIFF_W-1:0] wby2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      act2 <= act1;
      deg2 <= (px1[0] == px1[1] && py1[0] == py1[1]) ||
              (px1[1] == px1[2] && py1[1] == py1[2]) ||
              (px1[2] == px1[0] && py1[2] == py1[0]);
      eax2[0] <= DIFF_W'(px1[1]) - DIFF_W'(px1[0]);
      eay2[0] <= DIFF_W'(py1[1]) - DIFF_W'(py1[0]);
      eax2[1] <= DIFF_W'(px1[2]) - DIFF_W'(px1[1]);
      eay2[1] <= DIFF_W'(py1[2]) - DIFF_W'(py1[1]);
      eax2[2] <= DIFF_W'(px1[0]) - DIFF_W'(px1[2]);
      eay2[2] <= DIFF_W'(py1[0]) - DIFF_W'(py1[2]);
      ebx2[0] <= sbx[1] - sbx[0];
      eby2[0] <= sby[1] - sby[0];
      ebx2[1] <= sbx[2] - sbx[1];
      eby2[1] <= sby[2] - sby[1];
      ebx2[2] <= sbx[0] - sbx[2];
      eby2[2] <= sby[0] - sby[2];
      for (int i = 0; i < 3; i++) begin
        wax2[i] <= DIFF_W'(qx1) - DIFF_W'(px1[i]);
        way2[i] <= DIFF_W'(qy1) - DIFF_W'(py1[i]);
        wbx2[i] <= BDIFF_W'(qx1) - sbx[i];
        wby2[i] <= BDIFF_W'(qy1) - sby[i];
      end
    end
  end

  // stage 3: cross product terms
  logic                      v3, act3, deg3;
  logic signed [DIFF_W-1:0]  eax3 [3];
  logic signed [DIFF_W-1:0]  eay3 [3];
  logic signed [DIFF_W-1:0]  wax3 [3];
  logic signed [DIFF_W-1:0]  way3 [3];
  logic signed [PROD_W-1:0]  pay3 [3];
  logic signed [PROD_W-1:0]  pax3 [3];
  logic signed [BPROD_W-1:0] pby3 [3];
  logic signed [BPROD_W-1:0] pbx3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      act3 <= act2;
      deg3 <= deg2;
      for (int i = 0; i < 3; i++) begin
        eax3[i] <= eax2[i];
        eay3[i] <= eay2[i];
        wax3[i] <= wax2[i];
        way3[i] <= way2[i];
        pay3[i] <= eax2[i] * way2[i];
        pax3[i] <= eay2[i] * wax2[i];
        pby3[i] <= ebx2[i] * wby2[i];
        pbx3[i] <= eby2[i] * wbx2[i];
      end
    end
  end

  // stage 4: side tests, pick the first edge the point lies outside of
  logic signed [CROSS_W-1:0]  cra [3];
  logic signed [BCROSS_W-1:0] crb [3];
  logic [2:0]                 oa, ob;
  logic signed [DIFF_W-1:0]   ex_s, ey_s, wix_s, wiy_s, wjx_s, wjy_s;
  logic signed [CROSS_W-1:0]  cr_s;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cra[i] = CROSS_W'(pay3[i]) - CROSS_W'(pax3[i]);
      crb[i] = BCROSS_W'(pby3[i]) - BCROSS_W'(pbx3[i]);
      oa[i]  = cra[i][CROSS_W-1];
      ob[i]  = crb[i][BCROSS_W-1];
    end
    if (oa[0]) begin
      ex_s = eax3[0]; ey_s = eay3[0]; cr_s = cra[0];
      wix_s = wax3[0]; wiy_s = way3[0]; wjx_s = wax3[1]; wjy_s = way3[1];
    end else if (oa[1]) begin
      ex_s = eax3[1]; ey_s = eay3[1]; cr_s = cra[1];
      wix_s = wax3[1]; wiy_s = way3[1]; wjx_s = wax3[2]; wjy_s = way3[2];
    end else begin
      ex_s = eax3[2]; ey_s = eay3[2]; cr_s = cra[2];
      wix_s = wax3[2]; wiy_s = way3[2]; wjx_s = wax3[0]; wjy_s = way3[0];
    end
  end

  logic                     v4;
  ctl_t                     ctl4;
  logic signed [DIFF_W-1:0] ex4, ey4, wix4, wiy4, wjx4, wjy4;
  logic signed [CROSS_W-1:0] cr4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      ctl4 <= '{action: act3, degenerate: deg3, in0: ~|oa, in1: ~|ob, default: 1'b0};
      ex4  <= ex_s;
      ey4  <= ey_s;
      wix4 <= wix_s;
      wiy4 <= wiy_s;
      wjx4 <= wjx_s;
      wjy4 <= wjy_s;
      cr4  <= cr_s;
    end
  end

  // stage 5: squares and dot products of the chosen edge
  logic                     v5;
  ctl_t                     ctl5;
  logic signed [DIFF_W-1:0] ex5, ey5, wix5, wiy5, wjx5, wjy5;
  logic [RAD_W-1:0]         crm5;
  logic signed [PROD_W-1:0] exx5, eyy5, exw5, eyw5, wixx5, wiyy5, wjxx5, wjyy5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      ctl5  <= ctl4;
      ex5   <= ex4;
      ey5   <= ey4;
      wix5  <= wix4;
      wiy5  <= wiy4;
      wjx5  <= wjx4;
      wjy5  <= wjy4;
      crm5  <= RAD_W'($unsigned(-cr4));
      exx5  <= ex4 * ex4;
      eyy5  <= ey4 * ey4;
      exw5  <= ex4 * wix4;
      eyw5  <= ey4 * wiy4;
      wixx5 <= wix4 * wix4;
      wiyy5 <= wiy4 * wiy4;
      wjxx5 <= wjx4 * wjx4;
      wjyy5 <= wjy4 * wjy4;
    end
  end

  // stage 6: squared lengths and projection
  logic                      v6;
  ctl_t                      ctl6;
  logic signed [DIFF_W-1:0]  ex6, ey6, wix6, wiy6, wjx6, wjy6;
  logic [RAD_W-1:0]          crm6, l26, ni6, nj6;
  logic signed [CROSS_W-1:0] dt6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      ctl6 <= ctl5;
      ex6  <= ex5;
      ey6  <= ey5;
      wix6 <= wix5;
      wiy6 <= wiy5;
      wjx6 <= wjx5;
      wjy6 <= wjy5;
      crm6 <= crm5;
      l26  <= $unsigned(exx5) + $unsigned(eyy5);
      ni6  <= $unsigned(wixx5) + $unsigned(wiyy5);
      nj6  <= $unsigned(wjxx5) + $unsigned(wjyy5);
      dt6  <= CROSS_W'(exw5) + CROSS_W'(eyw5);
    end
  end

  // stage 7: choose edge or corner, load the square root
  logic                     perp7, ci7;
  logic signed [DIFF_W-1:0] nx7, ny7;
  logic [RAD_W-1:0]         rad7;
  ctl_t                     ctl7;
  sq_t                      sq   [ROOT_W+1];
  logic                     sq_v [ROOT_W+1];

  always_comb begin
    ci7   = dt6[CROSS_W-1] || (dt6 == '0);
    perp7 = !ci7 && (dt6 < $signed({1'b0, l26}));
    if (perp7) begin
      rad7 = l26; nx7 = -ey6; ny7 = ex6;
    end else if (ci7) begin
      rad7 = ni6; nx7 = -wix6; ny7 = -wiy6;
    end else begin
      rad7 = nj6; nx7 = -wjx6; ny7 = -wjy6;
    end
    ctl7        = ctl6;
    ctl7.perp   = perp7;
    ctl7.gx_neg = nx7[DIFF_W-1];
    ctl7.gy_neg = ny7[DIFF_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v6;
    end
    if (en) begin
      sq[0].ctl    <= ctl7;
      sq[0].rem    <= rad7;
      sq[0].root   <= '0;
      sq[0].num    <= crm6;
      sq[0].gx_mag <= mag(nx7);
      sq[0].gy_mag <= mag(ny7);
    end
  end

  // square root, one bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - k;
    logic [TEST_W-1:0] test;
    sq_t               nxt;

    always_comb begin
      nxt  = sq[k];
      test = (TEST_W'(sq[k].root) << (B + 1)) + (TEST_W'(1) << (2 * B));
      if (TEST_W'(sq[k].rem) >= test) begin
        nxt.rem  = sq[k].rem - RAD_W'(test);
        nxt.root = sq[k].root | (ROOT_W'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
      if (en) begin
        sq[k+1] <= nxt;
      end
    end
  end

  // load the dividers
  dv_t  dv   [DIST_W+1];
  logic dv_v [DIST_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[ROOT_W];
    end
    if (en) begin
      dv[0].ctl  <= sq[ROOT_W].ctl;
      dv[0].sat  <= (sq[ROOT_W].num >> DIST_W) >= RAD_W'(sq[ROOT_W].root);
      dv[0].root <= sq[ROOT_W].root;
      dv[0].drem <= sq[ROOT_W].num;
      dv[0].dq   <= '0;
      dv[0].xrem <= GNUM_W'(sq[ROOT_W].gx_mag) << GFRAC;
      dv[0].yrem <= GNUM_W'(sq[ROOT_W].gy_mag) << GFRAC;
      dv[0].xq   <= '0;
      dv[0].yq   <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIST_W; k++) begin : g_div
    localparam int BD = DIST_W - 1 - k;
    localparam bit GA = (k < GQ_W);
    localparam int BG = GA ? (GQ_W - 1 - k) : 0;
    logic [RAD_W-1:0]  dstep;
    logic [GNUM_W-1:0] gstep;
    dv_t               nxt;

    always_comb begin
      nxt   = dv[k];
      dstep = RAD_W'(dv[k].root) << BD;
      gstep = GNUM_W'(dv[k].root) << BG;
      if (dv[k].drem >= dstep) begin
        nxt.drem = dv[k].drem - dstep;
        nxt.dq   = dv[k].dq | (DIST_W'(1) << BD);
      end
      if (GA && dv[k].xrem >= gstep) begin
        nxt.xrem = dv[k].xrem - gstep;
        nxt.xq   = dv[k].xq | (GQ_W'(1) << BG);
      end
      if (GA && dv[k].yrem >= gstep) begin
        nxt.yrem = dv[k].yrem - gstep;
        nxt.yq   = dv[k].yq | (GQ_W'(1) << BG);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
      if (en) begin
        dv[k+1] <= nxt;
      end
    end
  end

  // output stage
  dv_t                      fin;
  logic                     zero_f;
  logic [DIST_W-1:0]        dist_f;
  logic signed [GRAD_W-1:0] gx_f, gy_f;
  out_t                     out_next;

  always_comb begin
    fin    = dv[DIST_W];
    zero_f = fin.ctl.degenerate || fin.ctl.action || fin.ctl.in0;
    if (fin.ctl.perp) begin
      dist_f = fin.sat ? DIST_MAX : fin.dq;
    end else begin
      dist_f = (fin.root > ROOT_W'(DIST_MAX)) ? DIST_MAX : fin.root[DIST_W-1:0];
    end
    gx_f = $signed({1'b0, fin.xq});
    gy_f = $signed({1'b0, fin.yq});
    if (fin.ctl.gx_neg) begin
      gx_f = -gx_f;
    end
    if (fin.ctl.gy_neg) begin
      gy_f = -gy_f;
    end
    if (fin.root == '0) begin
      gx_f = '0;
      gy_f = '0;
    end
    out_next.distance   = zero_f ? '0 : dist_f;
    out_next.grad_x     = zero_f ? '0 : gx_f;
    out_next.grad_y     = zero_f ? '0 : gy_f;
    out_next.contained  = !fin.ctl.degenerate &&
                          (fin.ctl.in0 || (fin.ctl.action && fin.ctl.in1));
    out_next.degenerate = fin.ctl.degenerate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[DIST_W];
    end
    if (en) begin
      out_data <= out_next;
    end
  end

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |->
      out_data.distance == '0 && !out_data.contained &&
      out_data.grad_x == '0 && out_data.grad_y == '0)
    else $error("degenerate result not cleared");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.grad_x <= GRAD_ONE && out_data.grad_x >= -GRAD_ONE &&
                  out_data.grad_y <= GRAD_ONE && out_data.grad_y >= -GRAD_ONE)
    else $error("gradient out of range");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.contained |->
      out_data.distance == '0 && out_data.grad_x == '0 && out_data.grad_y == '0)
    else $error("contained point with nonzero distance");

endmodule
`default_nettype wire
